// File: src/assert_macros.svh
// Assertion helpers for the request framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// File: src/mbrf_pkg.sv
`default_nettype none

package mbrf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PairW  = 16;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned IdxW   = 4;   // up to ten bytes per item

  localparam logic [CrcW-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CrcW-1:0] CRC_POLY = 16'hA001;

  // Function opcodes on the wire
  localparam logic [ByteW-1:0] OP_RD_REGS = 8'h03;
  localparam logic [ByteW-1:0] OP_DEV_ID  = 8'h2B;
  localparam logic [ByteW-1:0] MEI_DEV_ID = 8'h0E;
  localparam logic [ByteW-1:0] DEV_ID_RD  = 8'h01;
  localparam logic [ByteW-1:0] OP_RD_FILE = 8'h68;
  localparam logic [ByteW-1:0] OP_WR_FILE = 8'h69;
  localparam logic [ByteW-1:0] OP_WR_REGS = 8'h10;
  localparam logic [ByteW-1:0] OP_COIL    = 8'h05;

  // Request selector codes of the header item
  typedef enum logic [FuncW-1:0] {
    FN_RD_REGS = 3'd0,
    FN_DEV_ID  = 3'd1,
    FN_RD_FILE = 3'd2,
    FN_WR_FILE = 3'd3,
    FN_WR_REGS = 3'd4,
    FN_COIL    = 3'd5
  } func_e;

  // Item kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  // Control of the shared CRC unit
  typedef struct packed {
    logic             clear;
    logic             update;
    logic [ByteW-1:0] data;
  } crc_ctrl_t;

endpackage

`default_nettype wire

// File: src/mbrf_req_if.sv
`default_nettype none

// Request channel: header items and payload word pairs
interface mbrf_req_if import mbrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             item_kind;
  logic [FuncW-1:0] func;
  logic [ByteW-1:0] station_addr;
  logic [AddrW-1:0] data_addr;
  logic [ByteW-1:0] file_number;
  logic [ByteW-1:0] count;
  logic [PairW-1:0] payload_pair;

  modport source (output valid, item_kind, func, station_addr, data_addr, file_number,
                  count, payload_pair, input ready);
  modport sink   (input valid, item_kind, func, station_addr, data_addr, file_number,
                  count, payload_pair, output ready);
endinterface

`default_nettype wire

// File: src/mbrf_frm_if.sv
`default_nettype none

// Frame byte channel
interface mbrf_frm_if import mbrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last;
  logic             error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

`default_nettype wire

// File: src/mbrf_crc16.sv
`default_nettype none

// Modbus CRC-16 accumulator, one byte per update
module mbrf_crc16 import mbrf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire crc_ctrl_t       ctrl_i,
  output logic [CrcW-1:0]      crc_o
);

  logic [CrcW-1:0] crc_q, crc_d;
  logic [CrcW-1:0] upd;

  // Reflected byte update: eight shift/xor steps
  always_comb begin
    upd = crc_q ^ {{(CrcW-ByteW){1'b0}}, ctrl_i.data};
    for (int i = 0; i < ByteW; i++) begin
      if (upd[0]) begin
        upd = (upd >> 1) ^ CRC_POLY;
      end else begin
        upd = upd >> 1;
      end
    end
  end

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.clear) begin
      crc_d = CRC_INIT;
    end else if (ctrl_i.update) begin
      crc_d = upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

// File: src/modbus_rtu_request_framer.sv
// Modbus RTU request framer. Each item on req_i is captured on accept, then
// its frame bytes leave on frm_o at one byte per cycle while the sink is
// ready; req_i.ready stays low until the last byte of the item has moved
// into the output register. A header item yields 2 to 10 bytes (read
// device id: 7, read registers: 8, read file: 10, write registers: 7 or 9
// with count zero, write file: 8 or 10, coil: 2), a payload pair 2 or 4
// bytes, and a rejected item a single error byte. The pace is set by the
// byte sequencer, which feeds every data byte through one shared CRC-16
// unit (one byte per cycle) and then appends the CRC low byte first. Write
// requests expect their payload pairs as later items; a new header abandons
// any unfinished write frame.
`default_nettype none
`include "assert_macros.svh"

module modbus_rtu_request_framer import mbrf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mbrf_req_if.sink   req_i,
  mbrf_frm_if.source frm_o
);

  state_e state_q, state_d;

  // Captured item
  logic             kind_q;
  logic [FuncW-1:0] func_q;
  logic [ByteW-1:0] station_q;
  logic [AddrW-1:0] addr_q;
  logic [ByteW-1:0] file_q;
  logic [ByteW-1:0] count_q;
  logic [PairW-1:0] pair_q;

  // Sequence plan of the current item
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  dlen_q, dlen_d;
  logic             tail_q, tail_d;
  logic             err_q, err_d;
  logic [ByteW-1:0] words_q, words_d;

  // Output register
  logic             ovalid_q, ovalid_d;
  logic [ByteW-1:0] obyte_q, obyte_d;
  logic             olast_q, olast_d;
  logic             oerr_q, oerr_d;

  logic             accept, can_emit, emit;
  logic             hdr_bad;
  logic [IdxW-1:0]  hdr_len;
  logic [ByteW-1:0] pending;
  logic [ByteW-1:0] data_byte;
  logic [CrcW-1:0]  crc;
  crc_ctrl_t        crc_ctrl;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign can_emit    = !ovalid_q || frm_o.ready;
  assign emit        = (state_q == ST_EMIT) && can_emit;

  // Header decode: length, pending pairs, rejection
  always_comb begin
    hdr_bad = 1'b0;
    hdr_len = '0;
    pending = '0;
    case (func_e'(req_i.func))
      FN_RD_REGS: hdr_len = IdxW'(6);
      FN_DEV_ID:  hdr_len = IdxW'(5);
      FN_RD_FILE: hdr_len = IdxW'(8);
      FN_WR_FILE: begin
        hdr_len = IdxW'(8);
        hdr_bad = req_i.count[ByteW-1];
        pending = req_i.count;
      end
      FN_WR_REGS: begin
        hdr_len = IdxW'(7);
        hdr_bad = req_i.count[ByteW-1];
        pending = req_i.count;
      end
      FN_COIL: begin
        hdr_len = IdxW'(2);
        pending = ByteW'(2);
      end
      default: hdr_bad = 1'b1;
    endcase
  end

  // Data byte at the current position
  always_comb begin
    data_byte = '0;
    if (kind_q == KIND_PAYLOAD) begin
      data_byte = idx_q[0] ? pair_q[ByteW-1:0] : pair_q[PairW-1:ByteW];
    end else begin
      case (func_e'(func_q))
        FN_RD_REGS, FN_WR_REGS: begin
          case (idx_q)
            4'd0:    data_byte = station_q;
            4'd1:    data_byte = (func_e'(func_q) == FN_RD_REGS) ? OP_RD_REGS : OP_WR_REGS;
            4'd2:    data_byte = addr_q[15:8];
            4'd3:    data_byte = addr_q[7:0];
            4'd4:    data_byte = 8'h00;
            4'd5:    data_byte = count_q;
            4'd6:    data_byte = {count_q[ByteW-2:0], 1'b0};
            default: data_byte = '0;
          endcase
        end
        FN_DEV_ID: begin
          case (idx_q)
            4'd0:    data_byte = station_q;
            4'd1:    data_byte = OP_DEV_ID;
            4'd2:    data_byte = MEI_DEV_ID;
            4'd3:    data_byte = DEV_ID_RD;
            default: data_byte = 8'h00;
          endcase
        end
        FN_RD_FILE, FN_WR_FILE: begin
          case (idx_q)
            4'd0:    data_byte = station_q;
            4'd1:    data_byte = (func_e'(func_q) == FN_RD_FILE) ? OP_RD_FILE : OP_WR_FILE;
            4'd2:    data_byte = file_q;
            4'd3:    data_byte = addr_q[31:24];
            4'd4:    data_byte = addr_q[23:16];
            4'd5:    data_byte = addr_q[15:8];
            4'd6:    data_byte = addr_q[7:0];
            4'd7:    data_byte = count_q;
            default: data_byte = '0;
          endcase
        end
        FN_COIL: data_byte = idx_q[0] ? OP_COIL : station_q;
        default: data_byte = '0;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    dlen_d   = dlen_q;
    tail_d   = tail_q;
    err_d    = err_q;
    words_d  = words_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    oerr_d   = oerr_q;
    crc_ctrl = '{clear: 1'b0, update: 1'b0, data: data_byte};

    if (ovalid_q && frm_o.ready) begin
      ovalid_d = 1'b0;
    end

    // capture and plan a new item
    if (accept) begin
      state_d = ST_EMIT;
      idx_d   = '0;
      if (req_i.item_kind == KIND_PAYLOAD) begin
        err_d  = (words_q == '0);
        dlen_d = IdxW'(2);
        tail_d = (words_q == ByteW'(1));
        if (words_q != '0) begin
          words_d = words_q - ByteW'(1);
        end
      end else begin
        crc_ctrl.clear = 1'b1;
        err_d   = hdr_bad;
        dlen_d  = hdr_len;
        tail_d  = (pending == '0);
        words_d = hdr_bad ? '0 : pending;
      end
    end

    // one byte per cycle into the output register, while it is empty or being taken
    if (emit) begin
      ovalid_d = 1'b1;
      idx_d    = idx_q + IdxW'(1);
      olast_d  = 1'b0;
      oerr_d   = 1'b0;
      if (err_q) begin
        obyte_d = '0;
        olast_d = 1'b1;
        oerr_d  = 1'b1;
        state_d = ST_IDLE;
      end else if (idx_q < dlen_q) begin
        obyte_d         = data_byte;
        crc_ctrl.update = 1'b1;
        if ((idx_q == dlen_q - IdxW'(1)) && !tail_q) begin
          state_d = ST_IDLE;
        end
      end else if (idx_q == dlen_q) begin
        obyte_d = crc[ByteW-1:0];
      end else begin
        obyte_d        = crc[CrcW-1:ByteW];
        olast_d        = 1'b1;
        crc_ctrl.clear = 1'b1;
        state_d        = ST_IDLE;
      end
    end
  end

  mbrf_crc16 u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      dlen_q   <= '0;
      tail_q   <= 1'b0;
      err_q    <= 1'b0;
      words_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      dlen_q   <= dlen_d;
      tail_q   <= tail_d;
      err_q    <= err_d;
      words_q  <= words_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
    if (accept) begin
      kind_q    <= req_i.item_kind;
      func_q    <= req_i.func;
      station_q <= req_i.station_addr;
      addr_q    <= req_i.data_addr;
      file_q    <= req_i.file_number;
      count_q   <= req_i.count;
      pair_q    <= req_i.payload_pair;
    end
  end

  assign frm_o.valid    = ovalid_q;
  assign frm_o.out_byte = obyte_q;
  assign frm_o.last     = olast_q;
  assign frm_o.error    = oerr_q;

  `ASSERT_CLK(a_err_byte_zero, clk_i, rst_ni, (ovalid_q && oerr_q) |-> (obyte_q == '0 && olast_q), "error byte not zero or not last")
  `ASSERT_NEVER(a_idx_range, clk_i, rst_ni, (state_q == ST_EMIT) && !err_q && (idx_q > dlen_q + IdxW'(1)), "byte index past frame end")
  `ASSERT_CLK(a_crc_cleared, clk_i, rst_ni, (emit && !err_q && idx_q > dlen_q) |=> (crc == CRC_INIT), "CRC not cleared after frame end")
  `ASSERT_CLK(a_bad_header, clk_i, rst_ni, (accept && req_i.item_kind == KIND_HEADER && hdr_bad) |=> (err_q && words_q == '0), "bad header not rejected")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (ovalid_q && !frm_o.ready) |=> (ovalid_q && $stable(obyte_q) && $stable(olast_q) && $stable(oerr_q)), "output item changed while stalled")

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mbrf_pkg::*;

  // Selector codes the block must reject
  localparam logic [FuncW-1:0] FN_BAD_6 = 3'd6;
  localparam logic [FuncW-1:0] FN_BAD_7 = 3'd7;
  localparam logic [ByteW-1:0] MAX_WR_COUNT = 8'd127;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 120;

  typedef struct packed {
    logic             kind;
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] station;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] file;
    logic [ByteW-1:0] count;
    logic [PairW-1:0] pair;
  } req_item_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             err;
  } frm_byte_t;

  // One stimulus row; n_typed > 0 means the results are spelled out by hand
  typedef struct packed {
    req_item_t       it;
    int              n_typed;
    frm_byte_t [1:0] typed;
  } row_t;

  localparam frm_byte_t ERR_RESULT = '{data: 8'h00, last: 1'b1, err: 1'b1};
  localparam frm_byte_t NO_RESULT  = '{data: 8'h00, last: 1'b0, err: 1'b0};

  logic clk_i;
  logic rst_ni;

  mbrf_req_if req_if ();
  mbrf_frm_if frm_if ();

  modbus_rtu_request_framer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .frm_o  (frm_if)
  );

  // Frame shadow state
  logic [CrcW-1:0]  crc_acc;
  logic [ByteW-1:0] words_left;

  frm_byte_t item_bytes[$];
  frm_byte_t frame_bytes_due[$];
  row_t      dir_rows[$];
  row_t      cur_row;

  int send_gap_pct;
  int recv_stall_pct;
  int items_sent;
  int mismatches;
  int bytes_seen;
  int quiet_cycles;

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Sink back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    frm_if.ready = rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [CrcW-1:0] crc16_step(logic [CrcW-1:0] c, logic [ByteW-1:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void push_data(logic [ByteW-1:0] b);
    crc_acc = crc16_step(crc_acc, b);
    item_bytes.push_back('{data: b, last: 1'b0, err: 1'b0});
  endfunction

  // CRC goes out low byte first and closes the frame
  function automatic void push_crc();
    item_bytes.push_back('{data: crc_acc[7:0], last: 1'b0, err: 1'b0});
    item_bytes.push_back('{data: crc_acc[15:8], last: 1'b1, err: 1'b0});
    crc_acc    = CRC_INIT;
    words_left = '0;
  endfunction

  // Rejected item; shadow state goes back to its reset values
  function automatic void push_reject();
    item_bytes.push_back(ERR_RESULT);
    crc_acc    = CRC_INIT;
    words_left = '0;
  endfunction

  // Frame bytes one accepted item causes
  function automatic void predict_frame_bytes(req_item_t it);
    logic [ByteW-1:0] hdr[$];
    logic [ByteW-1:0] pend;
    pend = '0;
    if (it.kind == KIND_PAYLOAD) begin
      // stray pair: error result, state untouched
      if (words_left == 0) begin
        item_bytes.push_back(ERR_RESULT);
        return;
      end
      push_data(it.pair[15:8]);
      push_data(it.pair[7:0]);
      words_left = words_left - 1'b1;
      if (words_left == 0) push_crc();
      return;
    end
    // a header abandons whatever frame was open
    crc_acc    = CRC_INIT;
    words_left = '0;
    case (it.func)
      FN_RD_REGS: begin
        hdr = '{it.station, OP_RD_REGS, it.addr[15:8], it.addr[7:0], 8'h00, it.count};
      end
      FN_DEV_ID: begin
        hdr = '{it.station, OP_DEV_ID, MEI_DEV_ID, DEV_ID_RD, 8'h00};
      end
      FN_RD_FILE, FN_WR_FILE: begin
        if (it.func == FN_WR_FILE) begin
          if (it.count > MAX_WR_COUNT) begin
            push_reject();
            return;
          end
          pend = it.count;
        end
        hdr = '{it.station, (it.func == FN_RD_FILE) ? OP_RD_FILE : OP_WR_FILE, it.file,
                it.addr[31:24], it.addr[23:16], it.addr[15:8], it.addr[7:0], it.count};
      end
      FN_WR_REGS: begin
        if (it.count > MAX_WR_COUNT) begin
          push_reject();
          return;
        end
        pend = it.count;
        hdr = '{it.station, OP_WR_REGS, it.addr[15:8], it.addr[7:0], 8'h00, it.count,
                {it.count[6:0], 1'b0}};
      end
      FN_COIL: begin
        pend = 8'd2;
        hdr = '{it.station, OP_COIL};
      end
      default: begin
        push_reject();
        return;
      end
    endcase
    foreach (hdr[i]) push_data(hdr[i]);
    if (pend == 0) push_crc();
    else words_left = pend;
  endfunction

  // Prediction on accepted requests, comparison on accepted frame bytes
  always @(posedge clk_i) begin : bus_watch
    req_item_t seen;
    frm_byte_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen = '{kind: req_if.item_kind, func: req_if.func, station: req_if.station_addr,
                 addr: req_if.data_addr, file: req_if.file_number, count: req_if.count,
                 pair: req_if.payload_pair};
        item_bytes.delete();
        predict_frame_bytes(seen);
        if (cur_row.n_typed == 0) begin
          foreach (item_bytes[i]) frame_bytes_due.push_back(item_bytes[i]);
        end else begin
          for (int i = 0; i < cur_row.n_typed; i++) frame_bytes_due.push_back(cur_row.typed[i]);
        end
      end
      if (frm_if.valid && frm_if.ready) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: byte %0d unexpected, actual %02h last %0b error %0b", $time,
                   bytes_seen, frm_if.out_byte, frm_if.last, frm_if.error);
          mismatches++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (frm_if.out_byte !== want.data) begin
            $display("%0t: byte %0d out_byte expected %02h actual %02h", $time, bytes_seen,
                     want.data, frm_if.out_byte);
            mismatches++;
          end
          if (frm_if.last !== want.last) begin
            $display("%0t: byte %0d last expected %0b actual %0b", $time, bytes_seen,
                     want.last, frm_if.last);
            mismatches++;
          end
          if (frm_if.error !== want.err) begin
            $display("%0t: byte %0d error expected %0b actual %0b", $time, bytes_seen,
                     want.err, frm_if.error);
            mismatches++;
          end
        end
        bytes_seen++;
      end
      if ((req_if.valid && req_if.ready) || (frm_if.valid && frm_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Ends a hung run
  initial begin : watchdog
    wait (rst_ni === 1'b1);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("modbus_rtu_request_framer verification failed");
    $finish;
  end

  function automatic void add_row(logic kind, logic [FuncW-1:0] func, logic [ByteW-1:0] station,
                                  logic [AddrW-1:0] addr, logic [ByteW-1:0] file,
                                  logic [ByteW-1:0] count, logic [PairW-1:0] pair,
                                  int n_typed, frm_byte_t t0, frm_byte_t t1);
    row_t r;
    r.it       = '{kind: kind, func: func, station: station, addr: addr, file: file,
                   count: count, pair: pair};
    r.n_typed  = n_typed;
    r.typed[0] = t0;
    r.typed[1] = t1;
    dir_rows.push_back(r);
  endfunction

  function automatic row_t rand_row();
    row_t r;
    r.it.kind    = 1'($urandom_range(1));
    r.it.func    = FuncW'($urandom_range(7));
    r.it.station = ByteW'($urandom_range(255));
    r.it.addr    = $urandom;
    r.it.file    = ByteW'($urandom_range(255));
    r.it.count   = ByteW'($urandom_range(255));
    r.it.pair    = PairW'($urandom_range(65535));
    r.n_typed    = 0;
    r.typed      = '0;
    return r;
  endfunction

  // Present one item at the falling edge and hold it until taken
  task automatic send_item(input row_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    cur_row             = r;
    req_if.item_kind    = r.it.kind;
    req_if.func         = r.it.func;
    req_if.station_addr = r.it.station;
    req_if.data_addr    = r.it.addr;
    req_if.file_number  = r.it.file;
    req_if.count        = r.it.count;
    req_if.payload_pair = r.it.pair;
    req_if.valid        = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every frame byte has come out
  task automatic drain_frames();
    req_if.valid = 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk_i);
  endtask

  // One random request: mostly complete frames, some noise and cut-off writes
  task automatic random_frame();
    row_t r;
    int   sel;
    int   pairs;
    r   = rand_row();
    sel = $urandom_range(99);
    if (sel < 6) begin
      r.it.kind = KIND_PAYLOAD;
      send_item(r);
    end else if (sel < 11) begin
      r.it.kind = KIND_HEADER;
      r.it.func = $urandom_range(1) ? FN_BAD_6 : FN_BAD_7;
      send_item(r);
    end else begin
      r.it.kind = KIND_HEADER;
      r.it.func = FuncW'($urandom_range(5));
      if (r.it.func == FN_WR_FILE || r.it.func == FN_WR_REGS) begin
        sel = $urandom_range(99);
        if (sel < 85) r.it.count = ByteW'($urandom_range(4));
        else if (sel < 90) r.it.count = ByteW'($urandom_range(127, 5));
        else if (sel < 92) r.it.count = MAX_WR_COUNT;
        else r.it.count = ByteW'($urandom_range(255, 128));
      end
      pairs = 0;
      if (r.it.func == FN_COIL) pairs = 2;
      else if ((r.it.func == FN_WR_FILE || r.it.func == FN_WR_REGS) &&
               r.it.count <= MAX_WR_COUNT) pairs = r.it.count;
      send_item(r);
      // now and then the write is cut short by the next header
      if (pairs > 0 && $urandom_range(9) == 0) pairs = $urandom_range(pairs - 1);
      repeat (pairs) begin
        r = rand_row();
        r.it.kind = KIND_PAYLOAD;
        send_item(r);
      end
    end
  endtask

  task automatic random_phase(input int gap_pct, input int stall_pct);
    int target;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    target         = items_sent + ITEMS_PER_PHASE;
    while (items_sent < target) random_frame();
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.item_kind    = KIND_HEADER;
    req_if.func         = FN_RD_REGS;
    req_if.station_addr = '0;
    req_if.data_addr    = '0;
    req_if.file_number  = '0;
    req_if.count        = '0;
    req_if.payload_pair = '0;
    frm_if.ready        = 1'b0;
    crc_acc             = CRC_INIT;
    words_left          = '0;
    cur_row             = '0;
    send_gap_pct        = 18;
    recv_stall_pct      = 53;
    items_sent          = 0;
    mismatches          = 0;
    bytes_seen          = 0;
    quiet_cycles        = 0;

    // Directed rows: error results and the coil header are typed in
    add_row(KIND_PAYLOAD, FN_RD_REGS, 8'h00, 32'h0, 8'h00, 8'h00, 16'hFFFF, 1, ERR_RESULT,
            NO_RESULT);
    add_row(KIND_HEADER, FN_BAD_6, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 1, ERR_RESULT,
            NO_RESULT);
    add_row(KIND_HEADER, FN_BAD_7, 8'h00, 32'h0, 8'h00, 8'h00, 16'h0000, 1, ERR_RESULT,
            NO_RESULT);
    add_row(KIND_HEADER, FN_RD_REGS, 8'h00, 32'h0, 8'h00, 8'h00, 16'h0, 0, NO_RESULT,
            NO_RESULT);
    add_row(KIND_HEADER, FN_RD_REGS, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 0,
            NO_RESULT, NO_RESULT);
    add_row(KIND_HEADER, FN_DEV_ID, 8'h01, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 0,
            NO_RESULT, NO_RESULT);
    add_row(KIND_HEADER, FN_RD_FILE, 8'hA5, 32'h1234_5678, 8'hFF, 8'hFF, 16'h0, 0, NO_RESULT,
            NO_RESULT);
    add_row(KIND_HEADER, FN_RD_FILE, 8'h00, 32'h0, 8'h00, 8'h00, 16'h0, 0, NO_RESULT,
            NO_RESULT);
    // write counts past the limit
    add_row(KIND_HEADER, FN_WR_FILE, 8'h33, 32'h0000_0100, 8'h01, 8'd128, 16'h0, 1,
            ERR_RESULT, NO_RESULT);
    add_row(KIND_HEADER, FN_WR_REGS, 8'h44, 32'h0000_0200, 8'h02, 8'd128, 16'h0, 1,
            ERR_RESULT, NO_RESULT);
    add_row(KIND_HEADER, FN_WR_REGS, 8'h44, 32'h0000_0200, 8'h02, 8'hFF, 16'h0, 1,
            ERR_RESULT, NO_RESULT);
    // zero-count writes close the frame at once
    add_row(KIND_HEADER, FN_WR_REGS, 8'h12, 32'h0000_BEEF, 8'h00, 8'h00, 16'h0, 0, NO_RESULT,
            NO_RESULT);
    add_row(KIND_HEADER, FN_WR_FILE, 8'h13, 32'hFFFF_FFFF, 8'h7E, 8'h00, 16'h0, 0, NO_RESULT,
            NO_RESULT);
    // largest write, abandoned by the coil header
    add_row(KIND_HEADER, FN_WR_REGS, 8'h21, 32'h0000_FFFF, 8'h00, MAX_WR_COUNT, 16'h0, 0,
            NO_RESULT, NO_RESULT);
    add_row(KIND_PAYLOAD, FN_RD_REGS, 8'h00, 32'h0, 8'h00, 8'h00, 16'h8001, 0, NO_RESULT,
            NO_RESULT);
    add_row(KIND_HEADER, FN_COIL, 8'hFF, 32'h0, 8'h00, 8'h00, 16'h0, 2,
            '{data: 8'hFF, last: 1'b0, err: 1'b0}, '{data: OP_COIL, last: 1'b0, err: 1'b0});
    add_row(KIND_PAYLOAD, FN_RD_REGS, 8'h00, 32'h0, 8'h00, 8'h00, 16'hFFFF, 0, NO_RESULT,
            NO_RESULT);
    add_row(KIND_PAYLOAD, FN_RD_REGS, 8'h00, 32'h0, 8'h00, 8'h00, 16'h0000, 0, NO_RESULT,
            NO_RESULT);
    add_row(KIND_PAYLOAD, FN_RD_REGS, 8'h00, 32'h0, 8'h00, 8'h00, 16'h5AA5, 1, ERR_RESULT,
            NO_RESULT);
    add_row(KIND_HEADER, FN_WR_REGS, 8'h11, 32'h0000_00AB, 8'h00, 8'h01, 16'h0, 0, NO_RESULT,
            NO_RESULT);
    add_row(KIND_PAYLOAD, FN_RD_REGS, 8'h00, 32'h0, 8'h00, 8'h00, 16'h1234, 0, NO_RESULT,
            NO_RESULT);
    add_row(KIND_HEADER, FN_WR_FILE, 8'h22, 32'h8000_0001, 8'h5A, 8'h02, 16'h0, 0, NO_RESULT,
            NO_RESULT);
    add_row(KIND_PAYLOAD, FN_RD_REGS, 8'h00, 32'h0, 8'h00, 8'h00, 16'hAAAA, 0, NO_RESULT,
            NO_RESULT);
    // invalid selector in the middle of a write, then a pair with nothing open
    add_row(KIND_HEADER, FN_BAD_6, 8'h22, 32'h0, 8'h00, 8'h00, 16'h0, 1, ERR_RESULT,
            NO_RESULT);
    add_row(KIND_PAYLOAD, FN_RD_REGS, 8'h00, 32'h0, 8'h00, 8'h00, 16'h5555, 1, ERR_RESULT,
            NO_RESULT);

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    drain_frames();

    random_phase(18, 53);
    drain_frames();
    random_phase(53, 18);
    drain_frames();
    random_phase(0, 0);
    drain_frames();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("modbus_rtu_request_framer verification clean");
    end else begin
      $display("modbus_rtu_request_framer verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/mbrf_pkg.sv
src/mbrf_req_if.sv
src/mbrf_frm_if.sv
src/mbrf_crc16.sv
src/modbus_rtu_request_framer.sv
tb/sv/tb_top.sv
